FILE: hw/rtl/kpi_pkg.sv
// Shared types and constants for the k-tuple position index.
// No dependencies; imported by every module of the block.
package kpi_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = 13;
    localparam int MAX_LEN     = 4096;
    localparam int MAX_KTUP    = 7;
    localparam int RES_W       = 6;
    localparam int K_W         = 3;
    localparam int RADIX_W     = RES_W + 1;
    localparam int QUERY_W     = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_MAX  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [7:0]  residue;
        logic [QUERY_W-1:0] code_query;
    } t_in_item;

    typedef struct packed {
        logic             window_valid;
        logic [POS_W-1:0] window_start;
        logic [POS_W-1:0] prev_pos;
        logic [POS_W-1:0] head_pos;
    } t_out_item;

    typedef enum logic [1:0] {
        K_ZERO   = 2'd0,
        K_READ   = 2'd1,
        K_CLEAR  = 2'd2,
        K_WINDOW = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                             kind;
        logic [POS_W-1:0]                  start;
        logic [QUERY_W-1:0]                query;
        logic [K_W-1:0]                    k;
        logic [RADIX_W-1:0]                radix;
        logic [MAX_KTUP-1:0][RES_W-1:0]    res;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

endpackage

FILE: hw/rtl/kpi_front.sv
// Front end: accepts input transactions, tracks position and window, and
// classifies each one into a queue command. Depends on kpi_pkg.
module kpi_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  kpi_pkg::t_in_item         i_in_item,
    input  logic [kpi_pkg::RES_W-1:0] i_alphabet_max,
    input  logic [kpi_pkg::K_W-1:0]   i_window_length,
    input  logic                      i_queue_full,
    input  kpi_pkg::t_back_stat       i_back_stat,
    output logic                      o_push,
    output kpi_pkg::t_cmd             o_cmd
);
    import kpi_pkg::*;

    logic [POS_W-1:0]               r_pos, n_pos;
    logic [K_W-1:0]                 r_run, n_run;
    logic [MAX_KTUP-1:0][RES_W-1:0] r_res, n_res;
    logic [K_W-1:0]                 eff_k;
    logic                           res_ok;
    logic                           accept;
    logic [POS_W-1:0]               pos_inc;

    assign o_in_ready = !i_queue_full && !i_back_stat.init_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;

    assign eff_k   = (i_window_length == '0) ? K_W'(1) :
                     ((32'(i_window_length) > MAX_KTUP) ? K_W'(MAX_KTUP) : i_window_length);
    assign res_ok  = !i_in_item.residue[7] && !i_in_item.residue[6] &&
                     (i_in_item.residue[5:0] <= i_alphabet_max);
    assign pos_inc = r_pos + POS_W'(1);

    always_comb begin
        n_pos = r_pos;
        n_run = r_run;
        n_res = r_res;
        o_cmd = '0;
        o_cmd.kind  = K_ZERO;
        o_cmd.k     = eff_k;
        o_cmd.radix = RADIX_W'(i_alphabet_max) + RADIX_W'(1);
        o_cmd.query = i_in_item.code_query;
        case (i_in_item.op)
            OP_START: begin
                n_pos = '0;
                n_run = '0;
                n_res = '0;
                o_cmd.kind = K_CLEAR;
            end
            OP_READ: begin
                o_cmd.kind = K_READ;
            end
            OP_PUSH: begin
                if (r_pos < POS_W'(MAX_LEN)) begin
                    n_pos = pos_inc;
                    if (!res_ok) begin
                        n_run = '0;
                    end else begin
                        n_res[0] = i_in_item.residue[RES_W-1:0];
                        for (int i = 1; i < MAX_KTUP; i++) begin
                            n_res[i] = r_res[i-1];
                        end
                        if (32'(r_run) < MAX_KTUP) begin
                            n_run = r_run + K_W'(1);
                        end
                        if (n_run >= eff_k) begin
                            o_cmd.kind  = K_WINDOW;
                            o_cmd.res   = n_res;
                            o_cmd.start = pos_inc - POS_W'(eff_k) + POS_W'(1);
                        end
                    end
                end
            end
            default: begin
                o_cmd.kind = K_ZERO;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_run <= '0;
            r_res <= '0;
        end else if (accept) begin
            r_pos <= n_pos;
            r_run <= n_run;
            r_res <= n_res;
        end
    end

endmodule

FILE: hw/rtl/kpi_queue.sv
// Short command queue between front end and back end.
// Depends on kpi_pkg for the command type.
module kpi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kpi_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output kpi_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import kpi_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hw/rtl/kpi_back.sv
// Back end: Horner code build, head table lookup and update, clearing
// pass, and the output register. Depends on kpi_pkg.
module kpi_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  kpi_pkg::t_cmd        i_cmd,
    output logic                 o_pop,
    output kpi_pkg::t_back_stat  o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output kpi_pkg::t_out_item   o_out_item
);
    import kpi_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_HORNER   = 6'b000100,
        S_LOOKUP   = 6'b001000,
        S_WAIT_WIN = 6'b010000,
        S_WAIT_RD  = 6'b100000
    } t_state;

    localparam int SUM_W = ADDR_W + RADIX_W + 1;

    t_state             r_state, n_state;
    logic               r_init;
    logic [ADDR_W-1:0]  r_clr;
    t_cmd               r_cmd;
    logic [ADDR_W-1:0]  r_acc;
    logic               r_ovf;
    logic [K_W-1:0]     r_idx;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [POS_W-1:0]   r_table [TABLE_DEPTH];
    logic [POS_W-1:0]   r_rd_data;
    logic               mem_re, mem_we;
    logic [ADDR_W-1:0]  mem_ra, mem_wa;
    logic [POS_W-1:0]   mem_wd;

    logic               out_free;
    logic               out_post;
    logic [SUM_W-1:0]   sum;

    assign out_free      = !r_out_valid || i_out_ready;
    assign o_pop         = r_state[1] && !i_empty && out_free;
    assign o_stat.init_busy = r_init;
    assign o_out_valid   = r_out_valid;
    assign o_out_item    = r_out;

    assign sum = SUM_W'(r_acc) * SUM_W'(r_cmd.radix) + SUM_W'(r_cmd.res[r_idx]);

    always_comb begin
        n_state = r_state;
        mem_re  = 1'b0;
        mem_ra  = r_acc;
        mem_we  = 1'b0;
        mem_wa  = r_acc;
        mem_wd  = r_cmd.start;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                if (r_clr == ADDR_W'(TABLE_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_pop) begin
                    case (i_cmd.kind)
                        K_READ: begin
                            mem_re  = 1'b1;
                            mem_ra  = i_cmd.query[ADDR_W-1:0];
                            n_state = S_WAIT_RD;
                        end
                        K_CLEAR:  n_state = S_CLEAR;
                        K_WINDOW: n_state = S_HORNER;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_HORNER: begin
                if (r_idx == r_cmd.k - K_W'(1)) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                if (r_ovf) begin
                    n_state = S_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_WAIT_WIN;
                end
            end
            S_WAIT_WIN: begin
                mem_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_WAIT_RD: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            // read and window results are posted later; the rest at the pop
            S_IDLE:     out_post = o_pop && i_cmd.kind != K_READ && i_cmd.kind != K_WINDOW;
            S_LOOKUP:   out_post = r_ovf;
            S_WAIT_WIN: out_post = 1'b1;
            S_WAIT_RD:  out_post = 1'b1;
            default:    out_post = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_table[mem_wa] <= mem_wd;
        if (mem_re) r_rd_data <= r_table[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_init      <= 1'b1;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
                if (n_state == S_IDLE) r_init <= 1'b0;
            end
            if (r_state == S_IDLE && o_pop) r_clr <= '0;
            if (out_post) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    r_cmd <= i_cmd;
                    r_acc <= '0;
                    r_ovf <= 1'b0;
                    r_idx <= '0;
                    r_out <= '0;
                end
            end
            S_HORNER: begin
                // once past the table, the code can only grow
                r_acc <= sum[ADDR_W-1:0];
                r_ovf <= r_ovf || (sum >= SUM_W'(TABLE_DEPTH));
                r_idx <= r_idx + K_W'(1);
            end
            S_WAIT_WIN: begin
                r_out.window_valid <= 1'b1;
                r_out.window_start <= r_cmd.start;
                r_out.prev_pos     <= r_rd_data;
            end
            S_WAIT_RD: r_out.head_pos <= r_rd_data;
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/ktuple_position_index_unit.sv
// Top level of the k-tuple position index: configuration registers and the
// front end, queue and back end. Depends on kpi_pkg and the kpi_* modules.
//
// Every input transaction yields one result transaction, in order. The front
// end takes one transaction a cycle, unless the queue is full or the reset
// clearing pass runs, into a four-entry queue; the back end, owner of the
// single-port-per-direction head table, sets the rate: a push completing a
// window runs k Horner steps of one multiply-add each, a table read, then the
// registered read and write-back, or stops after the Horner steps when its
// code is outside the table; a read issues the table read and registers the
// data; a push with no window or an unused op ends at the pop; a start ends
// at the pop, then clears all 4096 table entries. After reset the same pass
// runs with input ready held low; configuration writes are taken at any time.
module ktuple_position_index_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  kpi_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output kpi_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_we,
    input  logic [kpi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kpi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kpi_pkg::*;

    logic [RES_W-1:0] r_alphabet_max;
    logic [K_W-1:0]   r_window_length;
    logic             queue_full, queue_empty, push, pop;
    t_cmd             push_cmd, head_cmd;
    t_back_stat       back_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_max  <= RES_W'(3);
            r_window_length <= K_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ALPHABET_MAX:  r_alphabet_max  <= i_cfg_data[RES_W-1:0];
                REG_WINDOW_LENGTH: r_window_length <= i_cfg_data[K_W-1:0];
                default: ;
            endcase
        end
    end

    kpi_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_item      (i_in_item),
        .i_alphabet_max (r_alphabet_max),
        .i_window_length(r_window_length),
        .i_queue_full   (queue_full),
        .i_back_stat    (back_stat),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    kpi_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (queue_full),
        .i_pop  (pop),
        .o_cmd  (head_cmd),
        .o_empty(queue_empty)
    );

    kpi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (queue_empty),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_stat     (back_stat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule
